### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; clk_i and rst_ni must be in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge out of reset
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true out of reset
`define SPQ_ASSERT_NEVER(label, expr, msg) \
  `SPQ_ASSERT(label, !(expr), msg)

`endif

### hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OCC_W    = 5;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [7:0] symbol;
    logic [7:0] prio;
  } entry_t;

  typedef struct packed {
    logic [7:0]       symbol_out;
    logic [7:0]       priority_out;
    logic [1:0]       status;
    logic [OCC_W-1:0] occupancy;
  } result_t;

  typedef struct packed {
    logic load;  // capture the incoming transaction
    logic exec;  // apply it to the queue and register the result
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

endpackage

`default_nettype wire

### hdl/spq_dpath.sv
// ----------------------------------------------------------------------------
// spq_dpath
// Row of sorted entry cells, input capture and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module spq_dpath import spq_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cmd_t       cmd_i,
  input  wire logic       action_i,
  input  wire logic [7:0] symbol_i,
  input  wire logic [7:0] priority_i,
  output result_t         res_o
);

  entry_t             entries_q [CAPACITY];
  entry_t             entries_d [CAPACITY];
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   count_inc;
  logic               act_q;
  logic [7:0]         sym_q, pri_q;
  result_t            res_q, res_d;
  logic [CAPACITY-1:0] gt, gt_prev;
  logic               full, empty;
  logic               ins_ok;
  logic               head_ordered;

  // every held entry with a larger priority number moves back one cell
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt[i] = (CNT_W'(i) < count_q) && (entries_q[i].prio > pri_q);
    end
    gt_prev = {gt[CAPACITY-2:0], 1'b0};
  end

  assign full      = (count_q == CNT_W'(CAPACITY));
  assign empty     = (count_q == '0);
  assign count_inc = count_q + 1'b1;

  always_comb begin
    logic [31:0] cnt_ext;
    entries_d = entries_q;
    count_d   = count_q;
    res_d     = '0;
    if (cmd_i.exec) begin
      if (act_q == ACT_INSERT) begin
        if (full) begin
          res_d.status = STAT_FULL;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (gt_prev[i]) begin
              entries_d[i] = entries_q[(i > 0) ? i - 1 : 0];
            end else if (gt[i] || (CNT_W'(i) == count_q)) begin
              entries_d[i] = '{symbol: sym_q, prio: pri_q};
            end
          end
          count_d = count_inc;
        end
      end else begin
        if (empty) begin
          res_d.status = STAT_EMPTY;
        end else begin
          res_d.symbol_out   = entries_q[0].symbol;
          res_d.priority_out = entries_q[0].prio;
          for (int i = 0; i < CAPACITY - 1; i++) begin
            entries_d[i] = entries_q[i+1];
          end
          count_d = count_q - 1'b1;
        end
      end
    end
    cnt_ext         = 32'(count_d);
    res_d.occupancy = cnt_ext[OCC_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      entries_q[i] <= entries_d[i];
    end
    if (cmd_i.load) begin
      act_q <= action_i;
      sym_q <= symbol_i;
      pri_q <= priority_i;
    end
    if (cmd_i.exec) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

  assign ins_ok       = cmd_i.exec && (act_q == ACT_INSERT) && !full;
  assign head_ordered = (entries_q[0].prio <= entries_q[1].prio);

  `SPQ_ASSERT_NEVER(a_count_bound, count_q > CNT_W'(CAPACITY), "entry count above capacity")
  `SPQ_ASSERT(a_insert_grows, ins_ok |=> (count_q == $past(count_inc)), "insert did not grow")
  `SPQ_ASSERT(a_head_sorted, (count_q > CNT_W'(1)) |-> head_ordered, "front entry out of order")

endmodule

`default_nettype wire

### hdl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: capture a transaction, apply it once the result slot is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module spq_ctrl import spq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_tvalid_i,
  output logic      s_tready_o,
  output logic      m_tvalid_o,
  input  wire logic m_tready_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || m_tready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        cmd_o.load = s_tvalid_i;
      end
      ST_EXEC: begin
        cmd_o.exec = out_free;
      end
      default: ;
    endcase
  end

  // hold the result until taken; a new one may replace it on the same edge
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_tvalid_o = out_valid_q;

  `SPQ_ASSERT(a_exec_free, cmd_o.exec |-> (!out_valid_q || m_tready_i), "result overwritten before taken")
  `SPQ_ASSERT(a_load_exec, cmd_o.load |=> (state_q == ST_EXEC), "captured transaction not applied")

endmodule

`default_nettype wire

### hdl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue of byte symbols, smallest priority number in front.
// ----------------------------------------------------------------------------
//  channel   dir  tdata (low bit up)                         tuser
//  s_axis    in   symbol_in[7:0] priority_in[15:8]           action
//  m_axis    out  symbol_out[7:0] priority_out[15:8]         -
//                 status[17:16] occupancy[22:18]
//
//  Each transaction is first captured, then applied in a step in which every
//  entry cell compares and shifts in parallel. A result waits in the output
//  register; a new transaction is captured meanwhile and is applied as soon
//  as that register is taken. Reset empties the queue at once.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue import spq_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // symbol_in, priority_in
  input  wire logic        s_axis_tuser,   // action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata    // symbol_out, priority_out, status, occupancy
);

  cmd_t    cmd;
  result_t res;

  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .cmd_o      (cmd)
  );

  spq_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .action_i   (s_axis_tuser),
    .symbol_i   (s_axis_tdata[7:0]),
    .priority_i (s_axis_tdata[15:8]),
    .res_o      (res)
  );

  assign m_axis_tdata = {1'b0, res.occupancy, res.status, res.priority_out, res.symbol_out};

endmodule

`default_nettype wire
